### hw/rtl/spt_pkg.sv
// ----------------------------------------------------------------------------
// spt_pkg: shared types and constants of the sorted process table
// Table size, id width, action and status codes, FSM states, and the structs
// that pass between the control logic and the entry cells.
// ----------------------------------------------------------------------------
package spt_pkg;

	localparam int TABLE_DEPTH = 32;
	localparam int ID_BITS     = 16;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int ACT_W       = 2;
	localparam int POS_W       = 5;
	localparam int ST_W        = 3;

	typedef logic [ID_BITS-1:0] spt_id_t;
	typedef logic [CNT_W-1:0]   spt_cnt_t;

	// action codes
	localparam logic [ACT_W-1:0] ACT_INSERT = ACT_W'(0);
	localparam logic [ACT_W-1:0] ACT_REMOVE = ACT_W'(1);
	localparam logic [ACT_W-1:0] ACT_GET    = ACT_W'(2);

	// status codes
	localparam logic [ST_W-1:0] ST_OK   = ST_W'(0);
	localparam logic [ST_W-1:0] ST_DUP  = ST_W'(1);
	localparam logic [ST_W-1:0] ST_FULL = ST_W'(2);
	localparam logic [ST_W-1:0] ST_MISS = ST_W'(3);
	localparam logic [ST_W-1:0] ST_PROT = ST_W'(4);

	// fixed first entry
	localparam spt_id_t ROOT_ID     = spt_id_t'(1);
	localparam spt_id_t ROOT_PARENT = spt_id_t'(0);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_UPD
	} spt_state_t;

	// what one slot shows its neighbors
	typedef struct packed {
		logic    vld;
		logic    gtv;
		spt_id_t id;
		spt_id_t parent;
	} spt_link_t;

	// broadcast control to every cell
	typedef struct packed {
		logic    cmp;
		logic    ins;
		logic    rem;
		spt_id_t key;
		spt_id_t ins_parent;
		spt_id_t rem_parent;
	} spt_ctl_t;

endpackage

### hw/rtl/spt_cell.sv
// ----------------------------------------------------------------------------
// spt_cell: one slot of the sorted process table
// Holds an id and a parent, compares its id with the broadcast key, and on an
// update takes its left neighbor (insert), its right neighbor (remove) or the
// new entry, reparenting on remove.
// ----------------------------------------------------------------------------
module spt_cell (
	input  logic               clk,
	input  spt_pkg::spt_ctl_t  ctl,
	input  logic               vld,
	input  spt_pkg::spt_link_t left,
	input  spt_pkg::spt_link_t right,
	output spt_pkg::spt_link_t link,
	output logic               hit
);

	spt_pkg::spt_id_t id_q;
	spt_pkg::spt_id_t parent_q;
	logic             gt_q;
	logic             ge_q;

	spt_pkg::spt_id_t id_d;
	spt_pkg::spt_id_t parent_d;
	spt_pkg::spt_id_t par_src;

	always_comb begin
		id_d     = id_q;
		parent_d = parent_q;
		par_src  = parent_q;
		if (ctl.ins) begin
			// entries above the key move one slot right
			if (left.gtv) begin
				id_d     = left.id;
				parent_d = left.parent;
			end else if (left.vld && (!vld || gt_q)) begin
				id_d     = ctl.key;
				parent_d = ctl.ins_parent;
			end
		end else if (ctl.rem) begin
			// the removed entry and all above it move one slot left
			if (vld && ge_q) begin
				id_d    = right.id;
				par_src = right.parent;
			end
			parent_d = (par_src == ctl.key) ? ctl.rem_parent : par_src;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			gt_q <= id_q > ctl.key;
			ge_q <= id_q >= ctl.key;
		end
		id_q     <= id_d;
		parent_q <= parent_d;
	end

	assign link.vld    = vld;
	assign link.gtv    = vld & gt_q;
	assign link.id     = id_q;
	assign link.parent = parent_q;
	assign hit         = vld & ge_q & ~gt_q;

endmodule

### hw/rtl/sorted_process_table_core.sv
// ----------------------------------------------------------------------------
// sorted_process_table_core: sorted table of process entries
// Insert, remove with reparenting, and read by position over a row of cells.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. Every command
// passes three steps: the word is latched, then all cells compare their ids
// with the key at once, then the cells shift, take the new entry or reparent,
// all in parallel. The result word is on status, found_id and found_parent
// for exactly one cycle with done high, in the cycle after the update; busy
// is already low then, so a new command may be issued in the same cycle the
// result is shown. The receiver cannot stall the result. The first entry, id 1
// with parent 0, is fixed and held as a constant; the other slots are cells
// whose contents are undefined until written, tracked by the entry count.
// ----------------------------------------------------------------------------
module sorted_process_table_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [spt_pkg::ACT_W-1:0]   action,
	input  logic [15:0]                 proc_id,
	input  logic [spt_pkg::POS_W-1:0]   position,
	output logic                        done,
	output logic [spt_pkg::ST_W-1:0]    status,
	output logic [15:0]                 found_id,
	output logic [15:0]                 found_parent
);

	localparam int D = spt_pkg::TABLE_DEPTH;

	// control state
	spt_pkg::spt_state_t state_q, state_d;
	spt_pkg::spt_cnt_t   count_q;
	logic                done_q;

	// latched command word
	logic [spt_pkg::ACT_W-1:0] act_q;
	spt_pkg::spt_id_t          key_q;
	logic [spt_pkg::POS_W-1:0] pos_q;

	// result word
	logic [spt_pkg::ST_W-1:0] status_q;
	spt_pkg::spt_id_t         fid_q;
	spt_pkg::spt_id_t         fpar_q;

	logic is_cmp, is_upd, accept;

	// cell row
	spt_pkg::spt_ctl_t  ctl;
	spt_pkg::spt_link_t link [0:D];
	logic [D:0]         vld;
	logic [D-1:1]       hit;

	// reductions over the row
	logic             any_hit;
	spt_pkg::spt_id_t rem_par;
	spt_pkg::spt_id_t last_id;
	spt_pkg::spt_id_t sel_id;
	spt_pkg::spt_id_t sel_par;

	// decision in the update cycle
	logic [spt_pkg::ST_W-1:0] st_d;
	spt_pkg::spt_id_t         fid_d;
	spt_pkg::spt_id_t         fpar_d;
	logic                     ins_ok, rem_ok;

	// ---------------- FSM ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			spt_pkg::S_IDLE: begin
				if (start) state_d = spt_pkg::S_CMP;
			end
			spt_pkg::S_CMP: state_d = spt_pkg::S_UPD;
			spt_pkg::S_UPD: state_d = spt_pkg::S_IDLE;
			default:        state_d = spt_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		busy   = 1'b1;
		is_cmp = 1'b0;
		is_upd = 1'b0;
		case (state_q)
			spt_pkg::S_IDLE: busy   = 1'b0;
			spt_pkg::S_CMP:  is_cmp = 1'b1;
			spt_pkg::S_UPD:  is_upd = 1'b1;
			default:         busy   = 1'b1;
		endcase
	end

	assign accept = start & ~busy;

	// slot valid flags from the entry count; slot 0 always valid
	for (genvar i = 0; i <= D; i++) begin : g_vld
		assign vld[i] = (32'(i) < 32'(count_q));
	end

	// fixed first entry and the empty end of the row
	assign link[0] = '{vld: 1'b1, gtv: 1'b0, id: spt_pkg::ROOT_ID,
		parent: spt_pkg::ROOT_PARENT};
	assign link[D] = '0;

	for (genvar i = 1; i < D; i++) begin : g_cell
		spt_cell u_cell (
			.clk   (clk),
			.ctl   (ctl),
			.vld   (vld[i]),
			.left  (link[i-1]),
			.right (link[i+1]),
			.link  (link[i]),
			.hit   (hit[i])
		);
	end

	// one-hot picks: the hit slot, the last valid slot, the slot at position
	always_comb begin
		any_hit = 1'b0;
		rem_par = '0;
		last_id = '0;
		sel_id  = '0;
		sel_par = '0;
		for (int i = 1; i < D; i++) begin
			any_hit = any_hit | hit[i];
			rem_par = rem_par | ({spt_pkg::ID_BITS{hit[i]}} & link[i].parent);
			last_id = last_id | ({spt_pkg::ID_BITS{vld[i] & ~vld[i+1]}} & link[i].id);
			sel_id  = sel_id | ({spt_pkg::ID_BITS{32'(pos_q) == i}} & link[i].id);
			sel_par = sel_par | ({spt_pkg::ID_BITS{32'(pos_q) == i}} & link[i].parent);
		end
	end

	// command decision, evaluated from the compare flags
	always_comb begin
		st_d   = spt_pkg::ST_MISS;
		fid_d  = '0;
		fpar_d = '0;
		ins_ok = 1'b0;
		rem_ok = 1'b0;
		case (act_q)
			spt_pkg::ACT_INSERT: begin
				if (any_hit || key_q == spt_pkg::ROOT_ID) begin
					st_d = spt_pkg::ST_DUP;
				end else if (count_q == spt_pkg::CNT_W'(D)) begin
					st_d = spt_pkg::ST_FULL;
				end else if (key_q == '0) begin
					st_d = spt_pkg::ST_MISS;
				end else begin
					st_d   = spt_pkg::ST_OK;
					ins_ok = 1'b1;
				end
			end
			spt_pkg::ACT_REMOVE: begin
				if (key_q == spt_pkg::ROOT_ID) begin
					st_d = spt_pkg::ST_PROT;
				end else if (!any_hit) begin
					st_d = spt_pkg::ST_MISS;
				end else begin
					st_d   = spt_pkg::ST_OK;
					rem_ok = 1'b1;
				end
			end
			spt_pkg::ACT_GET: begin
				if (32'(pos_q) < 32'(count_q)) begin
					st_d = spt_pkg::ST_OK;
					if (pos_q == '0) begin
						fid_d  = spt_pkg::ROOT_ID;
						fpar_d = spt_pkg::ROOT_PARENT;
					end else begin
						fid_d  = sel_id;
						fpar_d = sel_par;
					end
				end
			end
			default: st_d = spt_pkg::ST_MISS;
		endcase
	end

	// broadcast to the row; new parent is the largest id held now
	assign ctl.cmp        = is_cmp;
	assign ctl.ins        = is_upd & ins_ok;
	assign ctl.rem        = is_upd & rem_ok;
	assign ctl.key        = key_q;
	assign ctl.ins_parent = (count_q == spt_pkg::CNT_W'(1)) ? spt_pkg::ROOT_ID : last_id;
	assign ctl.rem_parent = rem_par;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spt_pkg::S_IDLE;
			count_q <= spt_pkg::CNT_W'(1);
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= is_upd;
			if (ctl.ins) begin
				count_q <= count_q + spt_pkg::CNT_W'(1);
			end else if (ctl.rem) begin
				count_q <= count_q - spt_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= action;
			key_q <= proc_id[spt_pkg::ID_BITS-1:0];
			pos_q <= position;
		end
		if (is_upd) begin
			status_q <= st_d;
			fid_q    <= fid_d;
			fpar_q   <= fpar_d;
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign found_id     = fid_q;
	assign found_parent = fpar_q;

`ifndef NO_ASSERTIONS
	// the first entry can never go, and the count never passes the table size
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != '0 && 32'(count_q) <= D)
		else $error("entry count out of range");

	// a result word only follows an update cycle
	a_done_after_upd: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == spt_pkg::S_UPD))
		else $error("done without update");

	// the count only moves in an update cycle
	a_count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != $past(count_q) |-> $past(state_q == spt_pkg::S_UPD))
		else $error("count changed outside update");

	// a successful insert grows the table by one
	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == spt_pkg::ST_OK && act_q == spt_pkg::ACT_INSERT)
		|-> count_q == spt_pkg::CNT_W'($past(count_q) + spt_pkg::CNT_W'(1)))
		else $error("insert ok without count increment");

	// a successful remove shrinks the table by one
	a_rem_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == spt_pkg::ST_OK && act_q == spt_pkg::ACT_REMOVE)
		|-> count_q == spt_pkg::CNT_W'($past(count_q) - spt_pkg::CNT_W'(1)))
		else $error("remove ok without count decrement");
`endif

endmodule
